// ----- rtl/bphre_pkg.sv -----
package bphre_pkg;

    // number of hold slots and release windows in use (1 or 2 each)
    localparam int HOLD_SLOTS      = 2;
    localparam int RELEASE_WINDOWS = 2;

    localparam int TICK_W  = 16;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // register map, byte address is 4 * index
    typedef enum logic [2:0] {
        REG_HOLD_DELAY_A  = 3'd0,
        REG_HOLD_REPEAT_A = 3'd1,
        REG_HOLD_DELAY_B  = 3'd2,
        REG_HOLD_REPEAT_B = 3'd3,
        REG_WIN_MIN_A     = 3'd4,
        REG_WIN_MAX_A     = 3'd5,
        REG_WIN_MIN_B     = 3'd6,
        REG_WIN_MAX_B     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [TICK_W-1:0] hold_delay_a;
        logic [TICK_W-1:0] hold_repeat_a;
        logic [TICK_W-1:0] hold_delay_b;
        logic [TICK_W-1:0] hold_repeat_b;
        logic [TICK_W-1:0] window_min_a;
        logic [TICK_W-1:0] window_max_a;
        logic [TICK_W-1:0] window_min_b;
        logic [TICK_W-1:0] window_max_b;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        hold_delay_a:  16'hFFFF,
        hold_repeat_a: 16'hFFFF,
        hold_delay_b:  16'hFFFF,
        hold_repeat_b: 16'hFFFF,
        window_min_a:  16'd1,
        window_max_a:  16'd0,
        window_min_b:  16'd1,
        window_max_b:  16'd0
    };

    typedef struct packed {
        logic              press_seen;
        logic              release_seen;
        logic [TICK_W-1:0] held_ticks;
        logic              hold_fire_a;
        logic              hold_fire_b;
        logic              window_hit;
        logic              window_index;
        logic              is_down;
    } t_result;

endpackage

// ----- rtl/bphre_ifs.sv -----
interface bphre_in_if;
    logic valid;
    logic ready;
    logic level_down;

    modport source (output valid, output level_down, input ready);
    modport sink   (input valid, input level_down, output ready);
endinterface

interface bphre_out_if;
    logic        valid;
    logic        ready;
    logic        press_seen;
    logic        release_seen;
    logic [15:0] held_ticks;
    logic        hold_fire_a;
    logic        hold_fire_b;
    logic        window_hit;
    logic        window_index;
    logic        is_down;

    modport source (
        output valid, input ready,
        output press_seen, output release_seen, output held_ticks,
        output hold_fire_a, output hold_fire_b, output window_hit,
        output window_index, output is_down
    );
    modport sink (
        input valid, output ready,
        input press_seen, input release_seen, input held_ticks,
        input hold_fire_a, input hold_fire_b, input window_hit,
        input window_index, input is_down
    );
endinterface

// ----- rtl/bphre_core.sv -----
module bphre_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_level_down,
    input  bphre_pkg::t_cfg     i_cfg,
    output bphre_pkg::t_result  o_result
);

    logic                          r_pressed, n_pressed;
    logic [bphre_pkg::TICK_W-1:0]  r_elapsed, n_elapsed;
    logic [bphre_pkg::TICK_W-1:0]  r_next_a, n_next_a;
    logic [bphre_pkg::TICK_W-1:0]  r_next_b, n_next_b;
    logic [bphre_pkg::TICK_W-1:0]  elapsed_inc;
    logic                          fire_a, fire_b, match_a, match_b;

    assign elapsed_inc = r_elapsed + 1'b1;

    assign fire_a  = (bphre_pkg::HOLD_SLOTS >= 1) && (elapsed_inc >= r_next_a);
    assign fire_b  = (bphre_pkg::HOLD_SLOTS >= 2) && (elapsed_inc >= r_next_b);
    assign match_a = (bphre_pkg::RELEASE_WINDOWS >= 1)
                     && (elapsed_inc >= i_cfg.window_min_a)
                     && (elapsed_inc <= i_cfg.window_max_a);
    assign match_b = (bphre_pkg::RELEASE_WINDOWS >= 2)
                     && (elapsed_inc >= i_cfg.window_min_b)
                     && (elapsed_inc <= i_cfg.window_max_b);

    always_comb begin
        n_pressed = i_level_down;
        n_elapsed = r_elapsed;
        n_next_a  = r_next_a;
        n_next_b  = r_next_b;
        o_result  = '0;
        o_result.is_down = i_level_down;
        if (i_level_down != r_pressed) begin
            if (i_level_down) begin
                // press: restart count and rearm both slots
                n_elapsed = '0;
                n_next_a  = i_cfg.hold_delay_a;
                n_next_b  = i_cfg.hold_delay_b;
                o_result.press_seen = 1'b1;
            end else begin
                // release: count one more tick, then pick the window (B wins)
                n_elapsed = elapsed_inc;
                o_result.release_seen = 1'b1;
                o_result.held_ticks   = elapsed_inc;
                o_result.window_hit   = match_a | match_b;
                o_result.window_index = match_b;
            end
        end else if (i_level_down) begin
            n_elapsed = elapsed_inc;
            o_result.held_ticks  = elapsed_inc;
            o_result.hold_fire_a = fire_a;
            o_result.hold_fire_b = fire_b;
            if (fire_a) begin
                n_next_a = r_next_a + i_cfg.hold_repeat_a;
            end
            if (fire_b) begin
                n_next_b = r_next_b + i_cfg.hold_repeat_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed <= 1'b0;
            r_elapsed <= '0;
            r_next_a  <= '0;
            r_next_b  <= '0;
        end else if (i_accept) begin
            r_pressed <= n_pressed;
            r_elapsed <= n_elapsed;
            r_next_a  <= n_next_a;
            r_next_b  <= n_next_b;
        end
    end

endmodule

// ----- rtl/button_press_hold_release_events_unit.sv -----
// channel     dir   handshake        word
// i_evt_in    in    valid / ready    level_down, one sample per tick
// o_evt_out   out   valid / ready    press/release flags, held_ticks, hold fires, window
// apb cfg     in    psel / penable   eight 16-bit registers at 4 * index
//
// one word accepted per cycle while i_evt_in.ready is high; its result is registered in the head or skid
// the tick state and the result are formed in one pass in bphre_core
// a two-entry output buffer (result register plus skid) parts the two sides,
// so i_evt_in.ready only drops while both entries hold unread results
// synchronous active-low reset clears tick state, registers and the buffer

module button_press_hold_release_events_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bphre_in_if.sink                          i_evt_in,
    bphre_out_if.source                       o_evt_out,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [bphre_pkg::PADDR_W-1:0]     i_paddr,
    input  logic [bphre_pkg::PDATA_W-1:0]     i_pwdata,
    output logic [bphre_pkg::PDATA_W-1:0]     o_prdata,
    output logic                              o_pready
);

    bphre_pkg::t_cfg     r_cfg;
    bphre_pkg::t_result  core_result;
    bphre_pkg::t_result  r_out, r_skid;
    logic                r_out_vld, r_skid_vld;
    logic                push, pop, cfg_wr;
    bphre_pkg::t_reg_idx reg_idx;
    logic [bphre_pkg::TICK_W-1:0] rd_val;

    // ------------------------------------------------------------ config port
    assign o_pready = 1'b1;
    assign reg_idx  = bphre_pkg::t_reg_idx'(i_paddr[4:2]);
    assign cfg_wr   = i_psel & i_penable & i_pwrite & o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= bphre_pkg::CFG_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                bphre_pkg::REG_HOLD_DELAY_A:  r_cfg.hold_delay_a  <= i_pwdata[15:0];
                bphre_pkg::REG_HOLD_REPEAT_A: r_cfg.hold_repeat_a <= i_pwdata[15:0];
                bphre_pkg::REG_HOLD_DELAY_B:  r_cfg.hold_delay_b  <= i_pwdata[15:0];
                bphre_pkg::REG_HOLD_REPEAT_B: r_cfg.hold_repeat_b <= i_pwdata[15:0];
                bphre_pkg::REG_WIN_MIN_A:     r_cfg.window_min_a  <= i_pwdata[15:0];
                bphre_pkg::REG_WIN_MAX_A:     r_cfg.window_max_a  <= i_pwdata[15:0];
                bphre_pkg::REG_WIN_MIN_B:     r_cfg.window_min_b  <= i_pwdata[15:0];
                bphre_pkg::REG_WIN_MAX_B:     r_cfg.window_max_b  <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back, zero-extended
    always_comb begin
        unique case (reg_idx)
            bphre_pkg::REG_HOLD_DELAY_A:  rd_val = r_cfg.hold_delay_a;
            bphre_pkg::REG_HOLD_REPEAT_A: rd_val = r_cfg.hold_repeat_a;
            bphre_pkg::REG_HOLD_DELAY_B:  rd_val = r_cfg.hold_delay_b;
            bphre_pkg::REG_HOLD_REPEAT_B: rd_val = r_cfg.hold_repeat_b;
            bphre_pkg::REG_WIN_MIN_A:     rd_val = r_cfg.window_min_a;
            bphre_pkg::REG_WIN_MAX_A:     rd_val = r_cfg.window_max_a;
            bphre_pkg::REG_WIN_MIN_B:     rd_val = r_cfg.window_min_b;
            bphre_pkg::REG_WIN_MAX_B:     rd_val = r_cfg.window_max_b;
            default:                      rd_val = '0;
        endcase
    end
    assign o_prdata = {{(bphre_pkg::PDATA_W-bphre_pkg::TICK_W){1'b0}}, rd_val};

    // ------------------------------------------------------------ tick logic
    assign i_evt_in.ready = ~r_skid_vld;
    assign push           = i_evt_in.valid & i_evt_in.ready;
    assign pop            = r_out_vld & o_evt_out.ready;

    bphre_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (push),
        .i_level_down (i_evt_in.level_down),
        .i_cfg        (r_cfg),
        .o_result     (core_result)
    );

    // ------------------------------------------------------------ output buffer
    // valid bits reset; the result words need none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || pop) begin
            // head is free this cycle: skid moves up first to keep order
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= push;
            end else begin
                r_out_vld  <= push;
                r_skid_vld <= 1'b0;
            end
        end else if (push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || pop) begin
            if (r_skid_vld) begin
                r_out  <= r_skid;
                r_skid <= core_result;
            end else begin
                r_out  <= core_result;
            end
        end else if (push) begin
            r_skid <= core_result;
        end
    end

    assign o_evt_out.valid        = r_out_vld;
    assign o_evt_out.press_seen   = r_out.press_seen;
    assign o_evt_out.release_seen = r_out.release_seen;
    assign o_evt_out.held_ticks   = r_out.held_ticks;
    assign o_evt_out.hold_fire_a  = r_out.hold_fire_a;
    assign o_evt_out.hold_fire_b  = r_out.hold_fire_b;
    assign o_evt_out.window_hit   = r_out.window_hit;
    assign o_evt_out.window_index = r_out.window_index;
    assign o_evt_out.is_down      = r_out.is_down;

endmodule

// ----- rtl/bphre_chk.sv -----
module bphre_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_press_seen,
    input logic        i_release_seen,
    input logic [15:0] i_held_ticks,
    input logic        i_hold_fire_a,
    input logic        i_hold_fire_b,
    input logic        i_window_hit,
    input logic        i_window_index,
    input logic        i_is_down
);

    // a press word starts the count at zero and reports the button down
    a_press_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_press_seen) |-> (i_held_ticks == 16'd0 && i_is_down
                                        && !i_release_seen))
        else $error("press word malformed");

    // hold fires only on held ticks
    a_fire_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_hold_fire_a || i_hold_fire_b)) |-> (i_is_down && !i_press_seen))
        else $error("hold fire outside a held tick");

    // window result only on a release, with the button up
    a_window_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_window_hit || i_window_index)) |-> (i_release_seen && !i_is_down
                                                          && i_window_hit))
        else $error("window result outside a release");

    // stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_press_seen)
            && $stable(i_release_seen) && $stable(i_held_ticks)
            && $stable(i_hold_fire_a) && $stable(i_hold_fire_b)
            && $stable(i_window_hit) && $stable(i_window_index) && $stable(i_is_down)))
        else $error("stalled output word changed");

endmodule

bind button_press_hold_release_events_unit bphre_chk u_bphre_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_evt_out.valid),
    .i_ready        (o_evt_out.ready),
    .i_press_seen   (o_evt_out.press_seen),
    .i_release_seen (o_evt_out.release_seen),
    .i_held_ticks   (o_evt_out.held_ticks),
    .i_hold_fire_a  (o_evt_out.hold_fire_a),
    .i_hold_fire_b  (o_evt_out.hold_fire_b),
    .i_window_hit   (o_evt_out.window_hit),
    .i_window_index (o_evt_out.window_index),
    .i_is_down      (o_evt_out.is_down)
);
